/* hw/rtl/rto_pkg.sv */
// ----------------------------------------------------------------------------
// rto_pkg: shared types and constants of the TCP retransmission timeout block
// Field widths, request kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package rto_pkg;

    localparam int unsigned TICK_W    = 32;
    localparam int unsigned MS_W      = 32;
    localparam int unsigned RETRY_W   = 8;
    localparam int unsigned MIN_W     = 16;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned OUT_W     = 3 * MS_W + RETRY_W + 1;
    localparam int unsigned OUT_PAD_W = ((OUT_W + 7) / 8) * 8;
    localparam int unsigned ADDR_W    = 5;

    // Request kinds carried on the input side channel
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_TIMEOUT = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_RESET   = 2'd3
    } kind_t;

    // Register word indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_RTO_MIN  = 3'd0,
        REG_RTO_MAX  = 3'd1,
        REG_RTO_INIT = 3'd2,
        REG_TICK_HZ  = 3'd3,
        REG_RETRY    = 3'd4
    } reg_idx_t;

    localparam logic [MIN_W-1:0]   RTO_MIN_RST  = 16'd1000;
    localparam logic [MS_W-1:0]    RTO_MAX_RST  = 32'd60000;
    localparam logic [MS_W-1:0]    RTO_INIT_RST = 32'd1000;
    localparam logic [MS_W-1:0]    TICK_HZ_RST  = 32'd1000;
    localparam logic [RETRY_W-1:0] RETRY_RST    = 8'd8;
    localparam logic [MS_W-1:0]    VAR_RST      = 32'd750;
    localparam logic [RETRY_W-1:0] RETRY_SAT    = 8'd255;

    // Ticks are scaled by ms per second before the divide
    localparam int unsigned DVD_W     = TICK_W + 10;
    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned ALU_W     = DVD_W + 1;
    localparam int unsigned ACC_W     = MS_W + 3;

endpackage

/* hw/rtl/tcp_rto_estimator.sv */
// ----------------------------------------------------------------------------
// tcp_rto_estimator: Jacobson/Karels retransmission timeout estimator
// Tracks smoothed rtt, rtt variation, timeout and retry count per connection.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+--------------------------------------
//  s_      | in        | tvalid / tready  | tdata: elapsed_ticks; tuser: kind
//  m_      | out       | tvalid / tready  | tdata: timeout, srtt, var, retries, abort
//  apb     | in        | psel/penable     | five config registers at 4*i
//
//  Steps: an rtt sample runs the 42-step restoring divide
//  (ticks * 1000 / tick_rate_hz) on the shared 43-bit add/sub unit, then
//  the update steps on that same unit. A timeout, ack progress and
//  connection reset skip the divide.
//  Reset: aresetn, synchronous, active low; config registers return to their
//  defaults and the estimator state to its initial values.
//  Stalls: s_tready is high only while the sequencer is idle; a held result in
//  the output register does not block the next request, only its completion.
//
module tcp_rto_estimator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rto_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rto_pkg::TICK_W-1:0]          s_tdata,   // [31:0] elapsed_ticks
    input  logic [rto_pkg::KIND_W-1:0]          s_tuser,   // [1:0] kind
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rto_pkg::OUT_PAD_W-1:0]       m_tdata    // [31:0] timeout_ms,
                                                           // [63:32] smoothed_rtt_ms,
                                                           // [95:64] rtt_var_ms,
                                                           // [103:96] retries,
                                                           // [104] abort_flag,
                                                           // [111:105] zero
);

    localparam int unsigned MS_W    = rto_pkg::MS_W;
    localparam int unsigned DVD_W   = rto_pkg::DVD_W;
    localparam int unsigned ALU_W   = rto_pkg::ALU_W;
    localparam int unsigned ACC_W   = rto_pkg::ACC_W;
    localparam int unsigned RETRY_W = rto_pkg::RETRY_W;
    localparam int unsigned CNT_W   = $clog2(rto_pkg::DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CONV, S_DIFF1, S_DIFF2, S_VAR1, S_VAR2,
        S_SRTT1, S_SRTT2, S_RTO1, S_RTO2, S_TO1, S_CLAMP, S_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rto_pkg::MIN_W-1:0] cfg_min_reg;
    logic [MS_W-1:0]           cfg_max_reg;
    logic [MS_W-1:0]           cfg_init_reg;
    logic [MS_W-1:0]           cfg_hz_reg;
    logic [RETRY_W-1:0]        cfg_limit_reg;
    logic                      cfg_wr;
    rto_pkg::reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = rto_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_min_reg   <= rto_pkg::RTO_MIN_RST;
            cfg_max_reg   <= rto_pkg::RTO_MAX_RST;
            cfg_init_reg  <= rto_pkg::RTO_INIT_RST;
            cfg_hz_reg    <= rto_pkg::TICK_HZ_RST;
            cfg_limit_reg <= rto_pkg::RETRY_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rto_pkg::REG_RTO_MIN:  cfg_min_reg   <= pwdata[rto_pkg::MIN_W-1:0];
                rto_pkg::REG_RTO_MAX:  cfg_max_reg   <= pwdata;
                rto_pkg::REG_RTO_INIT: cfg_init_reg  <= pwdata;
                rto_pkg::REG_TICK_HZ:  cfg_hz_reg    <= pwdata;
                rto_pkg::REG_RETRY:    cfg_limit_reg <= pwdata[RETRY_W-1:0];
                default: ;  // addresses past the register list are ignored
            endcase
        end
    end

    // Read back the addressed register, zero for unused addresses
    always_comb begin
        case (cfg_idx)
            rto_pkg::REG_RTO_MIN:  prdata = 32'(cfg_min_reg);
            rto_pkg::REG_RTO_MAX:  prdata = cfg_max_reg;
            rto_pkg::REG_RTO_INIT: prdata = cfg_init_reg;
            rto_pkg::REG_TICK_HZ:  prdata = cfg_hz_reg;
            rto_pkg::REG_RETRY:    prdata = 32'(cfg_limit_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Estimator state and sequencer registers
    // ------------------------------------------------------------------
    state_t              state_reg;
    logic [MS_W-1:0]     srtt_reg;
    logic [MS_W-1:0]     rttvar_reg;
    logic [MS_W-1:0]     rto_reg;
    logic [RETRY_W-1:0]  retry_reg;
    logic                abort_reg;
    logic [MS_W-1:0]     ms_reg;
    logic [MS_W-1:0]     diff_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [DVD_W-1:0]    dvd_reg;     // dividend bits shift out, quotient bits shift in
    logic [MS_W-1:0]     rem_reg;
    logic [MS_W-1:0]     divisor_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                m_tvalid_reg;
    logic [rto_pkg::OUT_PAD_W-1:0] m_tdata_reg;

    logic                s_accept;
    logic                out_free;
    logic [RETRY_W-1:0]  retry_next;
    logic [MS_W-1:0]     ms_next;
    logic [DVD_W-1:0]    dvd_next;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign retry_next = (retry_reg == rto_pkg::RETRY_SAT) ? retry_reg
                                                          : retry_reg + 1'b1;
    assign dvd_next   = DVD_W'(s_tdata) * DVD_W'(rto_pkg::MS_PER_S);

    // Quotient to milliseconds: saturate at 32 bits, floor at 1 ms
    always_comb begin
        if (dvd_reg[DVD_W-1:MS_W] != '0) begin
            ms_next = '1;
        end else if (dvd_reg[MS_W-1:0] == '0) begin
            ms_next = MS_W'(1);
        end else begin
            ms_next = dvd_reg[MS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Shared add/subtract unit; the top bit of a subtract is the borrow
    // ------------------------------------------------------------------
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W-1:0] alu_res;
    logic             alu_borrow;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_DIV: begin
                alu_a   = ALU_W'({rem_reg, dvd_reg[DVD_W-1]});
                alu_b   = ALU_W'(divisor_reg);
                alu_sub = 1'b1;
            end
            S_DIFF1: begin
                alu_a   = ALU_W'(srtt_reg);
                alu_b   = ALU_W'(ms_reg);
                alu_sub = 1'b1;
            end
            S_DIFF2: begin
                alu_a   = ALU_W'(ms_reg);
                alu_b   = ALU_W'(srtt_reg);
                alu_sub = 1'b1;
            end
            S_VAR1: begin
                alu_a = ALU_W'({rttvar_reg, 1'b0});
                alu_b = ALU_W'(rttvar_reg);
            end
            S_VAR2: begin
                alu_a = ALU_W'(acc_reg);
                alu_b = ALU_W'(diff_reg);
            end
            S_SRTT1: begin
                alu_a   = ALU_W'({srtt_reg, 3'b000});
                alu_b   = ALU_W'(srtt_reg);
                alu_sub = 1'b1;
            end
            S_SRTT2: begin
                alu_a = ALU_W'(acc_reg);
                alu_b = ALU_W'(ms_reg);
            end
            S_RTO1: begin
                alu_a   = ALU_W'({rttvar_reg, 2'b00});
                alu_b   = ALU_W'(cfg_min_reg);
                alu_sub = 1'b1;
            end
            S_RTO2: begin
                alu_a = ALU_W'(acc_reg);
                alu_b = ALU_W'(srtt_reg);
            end
            S_TO1: begin
                alu_a = ALU_W'(rto_reg);
                alu_b = ALU_W'(rto_reg);
            end
            S_CLAMP: begin
                alu_a   = ALU_W'(acc_reg);
                alu_b   = ALU_W'(cfg_max_reg);
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign alu_res    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_borrow = alu_res[ALU_W-1];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            srtt_reg     <= '0;
            rttvar_reg   <= rto_pkg::VAR_RST;
            rto_reg      <= rto_pkg::RTO_INIT_RST;
            retry_reg    <= '0;
            abort_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Drop the result once taken; S_OUT reloads it in its own arm
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        case (rto_pkg::kind_t'(s_tuser))
                            rto_pkg::KIND_SAMPLE: begin
                                abort_reg   <= 1'b0;
                                dvd_reg     <= dvd_next;
                                rem_reg     <= '0;
                                divisor_reg <= (cfg_hz_reg == '0) ? MS_W'(1) : cfg_hz_reg;
                                cnt_reg     <= CNT_W'(rto_pkg::DIV_STEPS - 1);
                                state_reg   <= S_DIV;
                            end
                            rto_pkg::KIND_TIMEOUT: begin
                                retry_reg <= retry_next;
                                abort_reg <= (retry_next >= cfg_limit_reg);
                                state_reg <= S_TO1;
                            end
                            rto_pkg::KIND_ACK: begin
                                abort_reg <= 1'b0;
                                retry_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            default: begin
                                abort_reg  <= 1'b0;
                                srtt_reg   <= '0;
                                rttvar_reg <= rto_pkg::VAR_RST;
                                rto_reg    <= cfg_init_reg;
                                retry_reg  <= '0;
                                state_reg  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle
                    if (!alu_borrow) begin
                        rem_reg <= alu_res[MS_W-1:0];
                    end else begin
                        rem_reg <= {rem_reg[MS_W-2:0], dvd_reg[DVD_W-1]};
                    end
                    dvd_reg <= {dvd_reg[DVD_W-2:0], !alu_borrow};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_CONV;
                    end
                end
                S_CONV: begin
                    ms_reg <= ms_next;
                    if (srtt_reg == '0) begin
                        // First sample seeds the estimates
                        srtt_reg   <= ms_next;
                        rttvar_reg <= ms_next >> 1;
                        state_reg  <= S_RTO1;
                    end else begin
                        state_reg <= S_DIFF1;
                    end
                end
                S_DIFF1: begin
                    diff_reg  <= alu_res[MS_W-1:0];
                    state_reg <= alu_borrow ? S_DIFF2 : S_VAR1;
                end
                S_DIFF2: begin
                    diff_reg  <= alu_res[MS_W-1:0];
                    state_reg <= S_VAR1;
                end
                S_VAR1: begin
                    acc_reg   <= alu_res[ACC_W-1:0];
                    state_reg <= S_VAR2;
                end
                S_VAR2: begin
                    rttvar_reg <= alu_res[MS_W+1:2];
                    state_reg  <= S_SRTT1;
                end
                S_SRTT1: begin
                    acc_reg   <= alu_res[ACC_W-1:0];
                    state_reg <= S_SRTT2;
                end
                S_SRTT2: begin
                    srtt_reg  <= alu_res[MS_W+2:3];
                    state_reg <= S_RTO1;
                end
                S_RTO1: begin
                    // Larger of 4*rttvar and the minimum
                    acc_reg   <= alu_borrow ? ACC_W'(cfg_min_reg)
                                            : ACC_W'({rttvar_reg, 2'b00});
                    state_reg <= S_RTO2;
                end
                S_RTO2: begin
                    acc_reg   <= alu_res[ACC_W-1:0];
                    state_reg <= S_CLAMP;
                end
                S_TO1: begin
                    acc_reg   <= alu_res[ACC_W-1:0];
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    rto_reg   <= alu_borrow ? acc_reg[MS_W-1:0] : cfg_max_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_tdata_reg  <= rto_pkg::OUT_PAD_W'({abort_reg, retry_reg,
                                                             rttvar_reg, srtt_reg,
                                                             rto_reg});
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/rto_checker.sv */
// ----------------------------------------------------------------------------
// rto_checker: port-level checks of the retransmission timeout estimator
// Watches the request and result streams over time.
// ----------------------------------------------------------------------------
module rto_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rto_pkg::OUT_PAD_W-1:0]       m_tdata
);

    // Busy after every request
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after an accepted request");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Abort only comes with a nonzero retry count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[104] |-> m_tdata[103:96] != '0)
        else $error("abort flagged with zero retries");

    // No sample yet: variation still at its initial value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[63:32] == '0 |-> m_tdata[95:64] == rto_pkg::VAR_RST)
        else $error("variation moved without a sample");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tcp_rto_estimator rto_checker u_rto_checker (.*);
